// File: hdl/csi_ruf_pkg.sv
// Shared types, constants and bit-field helpers for the CSI report field unpacker.
package csi_ruf_pkg;

    localparam int ReportWidth   = 32;
    localparam int LengthWidth   = 6;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;
    localparam int MaxReportBits = 32;
    localparam int PosWidth      = 5;
    localparam int FieldWidth    = 6;
    localparam int CqiWidth      = 4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_LEN_MISMATCH = 2'd1,
        ST_BAD_CONFIG   = 2'd2,
        ST_OVERSIZE     = 2'd3
    } t_status;

    // codebook selection
    typedef enum logic [1:0] {
        CB_ONE_PORT  = 2'd0,
        CB_TWO_PORT  = 2'd1,
        CB_FOUR_PORT = 2'd2,
        CB_OTHER     = 2'd3
    } t_codebook;

    // configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_CODEBOOK_KIND   = 3'd0,
        REG_RANK_MASK       = 3'd1,
        REG_RESOURCE_COUNT  = 3'd2,
        REG_ENABLE_CRI      = 3'd3,
        REG_ENABLE_RANK     = 3'd4,
        REG_ENABLE_LAYER    = 3'd5,
        REG_ENABLE_PRECODER = 3'd6,
        REG_ENABLE_CQI      = 3'd7
    } t_cfg_reg;

    // ceil(log2(n)) for a 7-bit count, saturating at 7
    function automatic logic [2:0] f_clog2_7(input logic [6:0] n);
        logic [2:0] w;
        priority if (n <= 7'd1)  w = 3'd0;
        else if (n <= 7'd2)      w = 3'd1;
        else if (n <= 7'd4)      w = 3'd2;
        else if (n <= 7'd8)      w = 3'd3;
        else if (n <= 7'd16)     w = 3'd4;
        else if (n <= 7'd32)     w = 3'd5;
        else if (n <= 7'd64)     w = 3'd6;
        else                     w = 3'd7;
        return w;
    endfunction

    // number of set bits in a byte
    function automatic logic [3:0] f_popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

    // Field of n bits starting at pos; the lowest report index is the field MSB.
    function automatic logic [FieldWidth-1:0] f_take(
        input logic [ReportWidth-1:0] bits,
        input logic [PosWidth-1:0]    pos,
        input logic [2:0]             n
    );
        logic [ReportWidth-1:0] s;
        logic [FieldWidth-1:0]  v;
        logic [2:0]             idx;
        s = bits >> pos;
        v = '0;
        for (int k = 0; k < FieldWidth; k++) begin
            idx = n - 3'(k) - 3'd1;
            if (3'(k) < n) begin
                v[k] = s[idx];
            end
        end
        return v;
    endfunction

endpackage

// File: hdl/csi_report_field_unpacker.sv
// Top level of the CSI report field unpacker: config registers and three-stage pipeline.
//
// Splits one packed CSI part 1 report per item into CRI, rank, layer index, PMI
// fields and wideband CQI, and checks its length against the size the configuration
// calls for. An item passes through three register stages, the last one being the
// output register, and one item can be taken every cycle unless the pipeline is full
// and the output is stalled. Stage one derives the field widths and the expected size
// from the configuration registers and sets the status; stage two pulls out CRI and
// rank; stage three pulls out layer index, PMI and CQI into the output register.
// Each stage has its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and a stalled output leaves the earlier stages free
// to fill. Configuration writes take effect at the next edge and must be made while
// no item is in flight.
module csi_report_field_unpacker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [csi_ruf_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [csi_ruf_pkg::CfgDataWidth-1:0]   i_cfg_data,
    // input item
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [csi_ruf_pkg::ReportWidth-1:0]    i_report_bits,
    input  logic [csi_ruf_pkg::LengthWidth-1:0]    i_report_length,
    // result item
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [5:0]                             o_resource_index,
    output logic [2:0]                             o_rank,
    output logic [1:0]                             o_layer_index,
    output logic [1:0]                             o_pmi_two_port,
    output logic [2:0]                             o_beam_index,
    output logic                                   o_layer_offset,
    output logic [1:0]                             o_cophase_index,
    output logic [3:0]                             o_wideband_cqi,
    output logic [5:0]                             o_expected_length,
    output logic [1:0]                             o_status
);
    import csi_ruf_pkg::*;

    // configuration registers
    t_codebook  r_codebook_kind;
    logic [7:0] r_rank_mask;
    logic [6:0] r_resource_count;
    logic       r_en_cri;
    logic       r_en_rank;
    logic       r_en_layer;
    logic       r_en_precoder;
    logic       r_en_cqi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codebook_kind  <= CB_ONE_PORT;
            r_rank_mask      <= 8'd1;
            r_resource_count <= 7'd1;
            r_en_cri         <= 1'b0;
            r_en_rank        <= 1'b0;
            r_en_layer       <= 1'b0;
            r_en_precoder    <= 1'b0;
            r_en_cqi         <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CODEBOOK_KIND:   r_codebook_kind  <= t_codebook'(i_cfg_data[1:0]);
                REG_RANK_MASK:       r_rank_mask      <= i_cfg_data;
                REG_RESOURCE_COUNT:  r_resource_count <= i_cfg_data[6:0];
                REG_ENABLE_CRI:      r_en_cri         <= i_cfg_data[0];
                REG_ENABLE_RANK:     r_en_rank        <= i_cfg_data[0];
                REG_ENABLE_LAYER:    r_en_layer       <= i_cfg_data[0];
                REG_ENABLE_PRECODER: r_en_precoder    <= i_cfg_data[0];
                REG_ENABLE_CQI:      r_en_cqi         <= i_cfg_data[0];
                default:             r_en_cqi         <= r_en_cqi;
            endcase
        end
    end

    // per-stage valid bits and load enables
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: widths, expected size, status ----------------
    logic [2:0]           n_cri_w;
    logic [1:0]           n_ri_w;
    logic [2:0]           n_lp_max;
    logic [PosWidth-1:0]  n_total;
    t_status              n_status;

    always_comb begin
        logic [3:0] pop;
        logic [2:0] pop_w;
        logic       bad;
        pop     = f_popcount8(r_rank_mask);
        pop_w   = f_clog2_7({3'd0, pop});
        n_cri_w = r_en_cri ? f_clog2_7(r_resource_count) : 3'd0;
        n_ri_w  = 2'd0;
        n_lp_max = 3'd0;
        unique case (r_codebook_kind)
            CB_TWO_PORT: begin
                n_ri_w = (pop_w >= 3'd1) ? 2'd1 : 2'd0;
                // rank 1: PMI 2 bits; rank 2: LI 1 bit + PMI 1 bit
                if (r_en_precoder) n_lp_max = 3'd2;
                else if (r_en_layer) n_lp_max = 3'd1;
            end
            CB_FOUR_PORT: begin
                n_ri_w = (pop_w >= 3'd2) ? 2'd2 : pop_w[1:0];
                // worst case over ranks: rank 2 (LI 1 + PMI 5) or rank 3, 4 (LI 2 + PMI 4)
                if (r_en_precoder && r_en_layer) n_lp_max = 3'd6;
                else if (r_en_precoder) n_lp_max = 3'd5;
                else if (r_en_layer) n_lp_max = 3'd2;
            end
            default: begin
                n_ri_w   = 2'd0;
                n_lp_max = 3'd0;
            end
        endcase
        if (!r_en_rank) n_ri_w = 2'd0;

        n_total = PosWidth'(n_cri_w) + PosWidth'(n_ri_w) + PosWidth'(n_lp_max)
                + (r_en_cqi ? PosWidth'(CqiWidth) : '0);

        bad = (r_codebook_kind == CB_OTHER) || (r_resource_count == 7'd0)
           || (r_resource_count > 7'd64)
           || ((r_codebook_kind != CB_ONE_PORT) && (r_rank_mask == 8'd0))
           || ((r_en_layer || r_en_precoder) && !r_en_rank);

        priority if (bad)                            n_status = ST_BAD_CONFIG;
        else if (32'(n_total) > MaxReportBits)       n_status = ST_OVERSIZE;
        else if (i_report_length != LengthWidth'(n_total)) n_status = ST_LEN_MISMATCH;
        else                                         n_status = ST_OK;
    end

    logic [ReportWidth-1:0] r_s1_bits;
    t_codebook              r_s1_kind;
    logic                   r_s1_el, r_s1_ep, r_s1_eq;
    logic [2:0]             r_s1_cri_w;
    logic [1:0]             r_s1_ri_w;
    logic [PosWidth-1:0]    r_s1_total;
    t_status                r_s1_status;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_bits   <= i_report_bits;
            r_s1_kind   <= r_codebook_kind;
            r_s1_el     <= r_en_layer;
            r_s1_ep     <= r_en_precoder;
            r_s1_eq     <= r_en_cqi;
            r_s1_cri_w  <= n_cri_w;
            r_s1_ri_w   <= n_ri_w;
            r_s1_total  <= n_total;
            r_s1_status <= n_status;
        end
    end

    // ---------------- stage 2: CRI and rank ----------------
    logic [FieldWidth-1:0] n_cri;
    logic [FieldWidth-1:0] n_ri;
    logic [2:0]            n_rank;
    logic [PosWidth-1:0]   n_pos_li;

    assign n_cri    = f_take(r_s1_bits, '0, r_s1_cri_w);
    assign n_ri     = f_take(r_s1_bits, PosWidth'(r_s1_cri_w), {1'b0, r_s1_ri_w});
    assign n_rank   = {1'b0, n_ri[1:0]} + 3'd1;
    assign n_pos_li = PosWidth'(r_s1_cri_w) + PosWidth'(r_s1_ri_w);

    logic [ReportWidth-1:0] r_s2_bits;
    t_codebook              r_s2_kind;
    logic                   r_s2_el, r_s2_ep, r_s2_eq;
    logic [FieldWidth-1:0]  r_s2_cri;
    logic [2:0]             r_s2_rank;
    logic [PosWidth-1:0]    r_s2_pos_li;
    logic [PosWidth-1:0]    r_s2_total;
    t_status                r_s2_status;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2_bits   <= r_s1_bits;
            r_s2_kind   <= r_s1_kind;
            r_s2_el     <= r_s1_el;
            r_s2_ep     <= r_s1_ep;
            r_s2_eq     <= r_s1_eq;
            r_s2_cri    <= n_cri;
            r_s2_rank   <= n_rank;
            r_s2_pos_li <= n_pos_li;
            r_s2_total  <= r_s1_total;
            r_s2_status <= r_s1_status;
        end
    end

    // ---------------- stage 3: LI, PMI, CQI and result masking ----------------
    logic [1:0] n_li;
    logic [1:0] n_pmi2;
    logic [2:0] n_beam;
    logic       n_offset;
    logic [1:0] n_cophase;
    logic [3:0] n_cqi;

    always_comb begin
        logic [2:0]          li_w;
        logic [2:0]          pmi_w;
        logic [PosWidth-1:0] cqi_pos;
        logic [PosWidth-1:0] pmi_pos;
        logic [PosWidth-1:0] cop_pos;
        logic [2:0]          cop_w;
        logic [FieldWidth-1:0] fld_li, fld_pmi2, fld_beam, fld_off, fld_cop, fld_cqi;
        li_w  = 3'd0;
        pmi_w = 3'd0;
        unique case (r_s2_kind)
            CB_TWO_PORT: begin
                li_w  = (r_s2_rank == 3'd2) ? 3'd1 : 3'd0;
                pmi_w = (r_s2_rank == 3'd2) ? 3'd1 : 3'd2;
            end
            CB_FOUR_PORT: begin
                li_w  = (r_s2_rank >= 3'd3) ? 3'd2 : ((r_s2_rank == 3'd2) ? 3'd1 : 3'd0);
                pmi_w = (r_s2_rank <= 3'd2) ? 3'd5 : 3'd4;
            end
            default: begin
                li_w  = 3'd0;
                pmi_w = 3'd0;
            end
        endcase
        if (!r_s2_el) li_w = 3'd0;
        if (!r_s2_ep) pmi_w = 3'd0;

        // PMI and CQI sit at the tail of the report, after the padding
        cqi_pos = r_s2_total - (r_s2_eq ? PosWidth'(CqiWidth) : '0);
        pmi_pos = cqi_pos - PosWidth'(pmi_w);
        cop_pos = pmi_pos + PosWidth'(3) + ((r_s2_rank == 3'd2) ? PosWidth'(1) : '0);
        cop_w   = (r_s2_rank == 3'd1) ? 3'd2 : 3'd1;

        fld_li   = f_take(r_s2_bits, r_s2_pos_li, li_w);
        fld_pmi2 = f_take(r_s2_bits, pmi_pos, pmi_w);
        fld_beam = f_take(r_s2_bits, pmi_pos, 3'd3);
        fld_off  = f_take(r_s2_bits, pmi_pos + PosWidth'(3), 3'd1);
        fld_cop  = f_take(r_s2_bits, cop_pos, cop_w);
        fld_cqi  = f_take(r_s2_bits, cqi_pos, 3'(CqiWidth));

        n_li      = fld_li[1:0];
        n_pmi2    = (r_s2_ep && r_s2_kind == CB_TWO_PORT) ? fld_pmi2[1:0] : 2'd0;
        n_beam    = (r_s2_ep && r_s2_kind == CB_FOUR_PORT) ? fld_beam[2:0] : 3'd0;
        n_offset  = r_s2_ep && (r_s2_kind == CB_FOUR_PORT) && (r_s2_rank == 3'd2)
                    && fld_off[0];
        n_cophase = (r_s2_ep && r_s2_kind == CB_FOUR_PORT) ? fld_cop[1:0] : 2'd0;
        n_cqi     = r_s2_eq ? fld_cqi[3:0] : 4'd0;
    end

    // output register; fields other than the size read as defaults unless status is ok
    logic w_ok;
    assign w_ok = (r_s2_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            o_resource_index  <= w_ok ? r_s2_cri : 6'd0;
            o_rank            <= w_ok ? r_s2_rank : 3'd1;
            o_layer_index     <= w_ok ? n_li : 2'd0;
            o_pmi_two_port    <= w_ok ? n_pmi2 : 2'd0;
            o_beam_index      <= w_ok ? n_beam : 3'd0;
            o_layer_offset    <= w_ok && n_offset;
            o_cophase_index   <= w_ok ? n_cophase : 2'd0;
            o_wideband_cqi    <= w_ok ? n_cqi : 4'd0;
            o_expected_length <= (r_s2_status == ST_BAD_CONFIG) ? 6'd0
                                                               : LengthWidth'(r_s2_total);
            o_status          <= r_s2_status;
        end
    end

endmodule
